// File: hw/rtl/plpc_pkg.sv
// Shared types, constants and command codes for the pinned LRU page cache.
// No dependencies.
package plpc_pkg;

  localparam int PAGES  = 64;
  localparam int IDX_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CNT_W  = $clog2(PAGES + 1);
  localparam int SLOT_W = 6;
  localparam int KEY_W  = 40;

  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_LOOKUP  = 3'd1;
  localparam logic [2:0] OP_PIN     = 3'd2;
  localparam logic [2:0] OP_UNPIN   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  layer;
    logic [31:0] block;
  } in_word_t;

  typedef struct packed {
    logic [5:0] slot;
    logic       hit;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    DC_NOP,
    DC_LOAD,
    DC_CLEAR,
    DC_KEY_CMP,
    DC_HIT_ROT,
    DC_PIN,
    DC_UNPIN,
    DC_FILL,
    DC_MISSING,
    DC_VIC_INIT,
    DC_VIC_CHK,
    DC_ROT_WR,
    DC_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       match;
    logic       last_key;
    logic       empty;
    logic       full;
    logic       rot_done;
    logic       vic_ok;
    logic       vic_last;
  } dp_stat_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    return SLOT_W'(idx);
  endfunction

endpackage

// File: hw/rtl/plpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/plpc_dp.sv
// Datapath: key and recency RAMs, pin marks, fill count, scan counters, result.
// Depends on plpc_pkg and plpc_ram.
module plpc_dp
  import plpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_word_t  in_data,
  output dp_stat_t  stat,
  output out_word_t out_data
);

  in_word_t          req_r;
  logic [IDX_W-1:0]  pos_r, carry_r, tgt_r, lim_r, fslot_r;
  logic [CNT_W-1:0]  fill_r;
  logic [PAGES-1:0]  pinned_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              hit_r;
  logic [1:0]        res_st_r;
  out_word_t         out_r;

  logic [KEY_W-1:0]  key_rdata, key_wdata;
  logic [IDX_W-1:0]  key_waddr, ord_rdata;
  logic              key_we, ord_we;
  logic [IDX_W-1:0]  fill_idx;

  assign fill_idx  = IDX_W'(fill_r);
  assign key_wdata = {req_r.layer, req_r.block};
  assign key_we    = (cmd.op == DC_FILL) || ((cmd.op == DC_VIC_CHK) && stat.vic_ok);
  assign key_waddr = (cmd.op == DC_FILL) ? fill_idx : ord_rdata;
  assign ord_we    = (cmd.op == DC_ROT_WR);

  plpc_ram #(.WIDTH(KEY_W), .DEPTH(PAGES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (pos_r),
    .rdata (key_rdata)
  );

  plpc_ram #(.WIDTH(IDX_W), .DEPTH(PAGES)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (pos_r),
    .wdata (carry_r),
    .raddr (pos_r),
    .rdata (ord_rdata)
  );

  always_comb begin
    stat.opcode   = req_r.opcode;
    stat.match    = (key_rdata == {req_r.layer, req_r.block});
    stat.last_key = ((CNT_W'(pos_r) + CNT_W'(1)) == fill_r);
    stat.empty    = (fill_r == '0);
    stat.full     = (fill_r == CNT_W'(PAGES));
    stat.rot_done = (ord_rdata == tgt_r) || (pos_r == lim_r);
    stat.vic_ok   = !pinned_r[ord_rdata];
    stat.vic_last = (pos_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      pinned_r <= '0;
    end else begin
      unique case (cmd.op)
        DC_LOAD: begin
          req_r      <= in_data;
          pos_r      <= '0;
          hit_r      <= 1'b0;
          res_slot_r <= '0;
          res_st_r   <= ST_OK;
        end
        DC_CLEAR: begin
          fill_r   <= '0;
          pinned_r <= '0;
        end
        DC_KEY_CMP: begin
          if (stat.match) begin
            fslot_r <= pos_r;
            hit_r   <= 1'b1;
          end else begin
            pos_r <= pos_r + IDX_W'(1);
          end
        end
        DC_HIT_ROT: begin
          carry_r    <= fslot_r;
          tgt_r      <= fslot_r;
          lim_r      <= IDX_W'(fill_r - CNT_W'(1));
          pos_r      <= '0;
          res_slot_r <= to_slot(fslot_r);
        end
        DC_PIN:   pinned_r[fslot_r] <= 1'b1;
        DC_UNPIN: pinned_r[fslot_r] <= 1'b0;
        DC_FILL: begin
          pinned_r[fill_idx] <= 1'b0;
          carry_r    <= fill_idx;
          tgt_r      <= fill_idx;
          lim_r      <= fill_idx;
          pos_r      <= '0;
          fslot_r    <= fill_idx;
          res_slot_r <= to_slot(fill_idx);
          fill_r     <= fill_r + CNT_W'(1);
        end
        DC_MISSING: res_st_r <= ST_MISSING;
        DC_VIC_INIT: pos_r <= IDX_W'(PAGES - 1);
        DC_VIC_CHK: begin
          if (stat.vic_ok) begin
            carry_r    <= ord_rdata;
            tgt_r      <= ord_rdata;
            lim_r      <= pos_r;
            pos_r      <= '0;
            fslot_r    <= ord_rdata;
            res_slot_r <= to_slot(ord_rdata);
          end else if (stat.vic_last) begin
            res_st_r <= ST_FULL;
          end else begin
            pos_r <= pos_r - IDX_W'(1);
          end
        end
        DC_ROT_WR: begin
          if (!stat.rot_done) begin
            carry_r <= ord_rdata;
            pos_r   <= pos_r + IDX_W'(1);
          end
        end
        DC_OUT: begin
          out_r.slot   <= res_slot_r;
          out_r.hit    <= hit_r;
          out_r.status <= res_st_r;
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_r;

endmodule

// File: hw/rtl/plpc_ctrl.sv
// Controller: sequences search, recency rotation and victim scan per request.
// Depends on plpc_pkg.
module plpc_ctrl
  import plpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRD, S_SCMP, S_HIT, S_MISS,
    S_RRD, S_RWR, S_VRD, S_VCHK, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = DC_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DC_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.opcode == OP_CLEAR) begin
          cmd.op    = DC_CLEAR;
          state_nxt = S_FIN;
        end else if (stat.opcode > OP_CLEAR) begin
          state_nxt = S_FIN;
        end else if (stat.empty) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        cmd.op = DC_KEY_CMP;
        if (stat.match) begin
          state_nxt = S_HIT;
        end else if (stat.last_key) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_HIT: begin
        if (stat.opcode == OP_PIN) begin
          cmd.op    = DC_PIN;
          state_nxt = S_FIN;
        end else if (stat.opcode == OP_UNPIN) begin
          cmd.op    = DC_UNPIN;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = DC_HIT_ROT;
          state_nxt = S_RRD;
        end
      end
      S_MISS: begin
        if (stat.opcode == OP_ACQUIRE) begin
          if (stat.full) begin
            cmd.op    = DC_VIC_INIT;
            state_nxt = S_VRD;
          end else begin
            cmd.op    = DC_FILL;
            state_nxt = S_RRD;
          end
        end else begin
          if (stat.opcode != OP_UNPIN) begin
            cmd.op = DC_MISSING;
          end
          state_nxt = S_FIN;
        end
      end
      S_RRD: state_nxt = S_RWR;
      S_RWR: begin
        cmd.op    = DC_ROT_WR;
        state_nxt = stat.rot_done ? S_FIN : S_RRD;
      end
      S_VRD: state_nxt = S_VCHK;
      S_VCHK: begin
        cmd.op = DC_VIC_CHK;
        if (stat.vic_ok) begin
          state_nxt = S_RRD;
        end else if (stat.vic_last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_VRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DC_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/pinned_lru_page_cache.sv
// Top level of the pinned LRU page cache: controller plus datapath.
// Depends on plpc_pkg, plpc_ctrl, plpc_dp.
//
// Usage: requests enter as one word on in_valid/in_ready/in_data (opcode,
// layer, block); each request yields exactly one result word on
// out_valid/out_ready/out_data (slot, hit, status), in request order.
// One request is processed at a time; in_ready is high while the block is
// idle, including while a finished result waits in the output register.
// The sequencer walks the key and recency RAMs, which have separate read
// and write ports and registered read data, one entry at a time:
//   clear / unknown opcode:   no RAM walk
//   key search:               keys compared in order up to the fill count
//   recency rotation:         positions shifted from front to the entry
//   victim scan when full:    positions checked from the least recent end
// Reset empties the cache (fill count and pin marks cleared); no clearing
// pass is needed. A stalled receiver holds the result word; the next
// request may complete internally but waits before overwriting it.
module pinned_lru_page_cache
  import plpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plpc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: hw/rtl/plpc_chk.sv
// Port-level checker for the pinned LRU page cache, bound to the top level.
// Depends on plpc_pkg.
module plpc_chk
  import plpc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_MISSING ||
                   out_data.status == ST_FULL))
    else $error("bad status code");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.status == ST_OK)
    else $error("hit with error status");

  a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot != '0 |-> out_data.status == ST_OK)
    else $error("slot reported with error status");

endmodule

bind pinned_lru_page_cache plpc_chk u_plpc_chk (.*);

// File: test/pinned_lru_page_cache_tb.sv
// Testbench for pinned_lru_page_cache: directed and random requests checked
// word by word against an in-bench LRU/pin predictor. Depends on plpc_pkg.
`timescale 1ns / 100ps

module pinned_lru_page_cache_tb;
  import plpc_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  pinned_lru_page_cache uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] page_block [PAGES];
  logic [7:0]  page_layer [PAGES];
  logic        page_pinned [PAGES];
  int          filled;
  int          lru_list [PAGES];

  out_word_t expected_words [$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        words_checked = 0;
  int        full_count = 0;
  int        evict_count = 0;
  int        hit_count = 0;
  int        ready_hold = 0;
  bit        stall_en = 1'b1;

  function automatic int find_page(logic [7:0] ly, logic [31:0] bl);
    for (int s = 0; s < filled; s++)
      if (page_layer[s] == ly && page_block[s] == bl) return s;
    return -1;
  endfunction

  function automatic void move_to_front(int pos);
    int s;
    s = lru_list[pos];
    for (int p = pos; p > 0; p--) lru_list[p] = lru_list[p - 1];
    lru_list[0] = s;
  endfunction

  function automatic int list_pos(int slot);
    for (int p = 0; p < filled; p++)
      if (lru_list[p] == slot) return p;
    return 0;
  endfunction

  function automatic out_word_t predict_cache(in_word_t w);
    out_word_t r;
    int f;
    int p;
    r = '0;
    if (w.opcode == OP_CLEAR) begin
      filled = 0;
      for (int s = 0; s < PAGES; s++) page_pinned[s] = 1'b0;
    end else if (w.opcode <= OP_UNPIN) begin
      f = find_page(w.layer, w.block);
      r.hit = (f >= 0);
      if (r.hit) hit_count++;
      case (w.opcode) inside
        OP_ACQUIRE, OP_LOOKUP: begin
          if (f >= 0) begin
            move_to_front(list_pos(f));
            r.slot = SLOT_W'(f);
          end else if (w.opcode == OP_LOOKUP) begin
            r.status = ST_MISSING;
          end else if (filled < PAGES) begin
            page_layer[filled] = w.layer;
            page_block[filled] = w.block;
            page_pinned[filled] = 1'b0;
            lru_list[filled] = filled;
            move_to_front(filled);
            r.slot = SLOT_W'(filled);
            filled++;
          end else begin
            p = PAGES - 1;
            while (p >= 0 && page_pinned[lru_list[p]]) p--;
            if (p < 0) begin
              r.status = ST_FULL;
              full_count++;
            end else begin
              r.slot = SLOT_W'(lru_list[p]);
              page_layer[lru_list[p]] = w.layer;
              page_block[lru_list[p]] = w.block;
              move_to_front(p);
              evict_count++;
            end
          end
        end
        OP_PIN: begin
          if (f >= 0) page_pinned[f] = 1'b1;
          else r.status = ST_MISSING;
        end
        default: begin
          if (f >= 0) page_pinned[f] = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_word(logic [2:0] op, logic [7:0] ly, logic [31:0] bl);
    in_word_t w;
    int gap;
    w.opcode = op;
    w.layer = ly;
    w.block = bl;
    gap = stall_en ? short_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(predict_cache(w));
    words_sent++;
  endtask

  // result side: random stalls, compare with the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data);
      end else begin
        e = expected_words.pop_front();
        if (out_data.slot !== e.slot || out_data.hit !== e.hit ||
            out_data.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slot %0d hit %0d status %0d, got %0d %0d %0d",
                     e.slot, e.hit, e.status, out_data.slot, out_data.hit,
                     out_data.status);
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 39) == 0) begin
      ready_hold = $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= stall_en ? ($urandom_range(0, 9) > 2) : 1'b1;
    end
  end

  // pool of keys kept small so hits and evictions are common
  function automatic logic [31:0] pool_block(int k);
    return (k % 5 == 0) ? 32'hFFFF_FFFF - 32'(k) : 32'(k);
  endfunction

  task automatic test_directed();
    send_word(OP_LOOKUP, 8'd0, 32'd0);
    send_word(OP_PIN, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_UNPIN, 8'd1, 32'd1);
    send_word(OP_ACQUIRE, 8'd0, 32'd0);
    send_word(OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_ACQUIRE, 8'd0, 32'd0);
    send_word(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_PIN, 8'd0, 32'd0);
    send_word(OP_UNPIN, 8'd0, 32'd0);
    send_word(OP_LOOKUP, 8'hFF, 32'h7FFF_FFFF);
    send_word(3'd5, 8'hAA, 32'h5555_5555);
    send_word(3'd6, 8'h55, 32'hAAAA_AAAA);
    send_word(3'd7, 8'd3, 32'd3);
    send_word(OP_CLEAR, 8'd0, 32'd0);
    send_word(OP_LOOKUP, 8'd0, 32'd0);
  endtask

  // fill all slots, pin every one, acquire must report full, then free one
  task automatic test_all_pinned();
    send_word(OP_CLEAR, 8'd0, 32'd0);
    for (int k = 0; k < PAGES; k++) send_word(OP_ACQUIRE, 8'd9, 32'(k));
    for (int k = 0; k < PAGES; k++) send_word(OP_PIN, 8'd9, 32'(k));
    send_word(OP_ACQUIRE, 8'd10, 32'd0);
    send_word(OP_UNPIN, 8'd9, 32'd17);
    send_word(OP_ACQUIRE, 8'd10, 32'd0);
    send_word(OP_ACQUIRE, 8'd10, 32'd1);
  endtask

  task automatic test_random(int n);
    int r;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_ACQUIRE;
      else if (r < 65) op = OP_LOOKUP;
      else if (r < 80) op = OP_PIN;
      else if (r < 94) op = OP_UNPIN;
      else if (r < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0)
        send_word(op, 8'($urandom), $urandom);
      else begin
        r = $urandom_range(0, 89);
        send_word(op, 8'(r % 3), pool_block(r));
      end
      if (i == n / 3) stall_en = 1'b0;
      if (i == n / 2) stall_en = 1'b1;
    end
  endtask

  initial begin
    filled = 0;
    for (int s = 0; s < PAGES; s++) page_pinned[s] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_all_pinned();
    test_random(500);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4 * PAGES + 20) @(posedge clk);
    $display("sent %0d requests, checked %0d results", words_sent, words_checked);
    $display("hits %0d, evictions %0d, all-pinned refusals %0d",
             hit_count, evict_count, full_count);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: pinned_lru_page_cache.f
hw/rtl/plpc_pkg.sv
hw/rtl/plpc_ram.sv
hw/rtl/plpc_dp.sv
hw/rtl/plpc_ctrl.sv
hw/rtl/pinned_lru_page_cache.sv
hw/rtl/plpc_chk.sv
test/pinned_lru_page_cache_tb.sv
